### sv/bcfs_pkg.sv
`timescale 1ns / 1ps
package bcfs_pkg;
    localparam int MaxYears = 64;
    localparam int IdxW = $clog2(MaxYears);
    localparam int CntW = $clog2(MaxYears + 1);
    localparam logic [47:0] AmtMax = 48'hFFFF_FFFF_FFFF;

    localparam logic [0:0] OpLoad = 1'b0;
    localparam logic [0:0] OpBond = 1'b1;

    localparam logic [1:0] StOk = 2'd0;
    localparam logic [1:0] StBase = 2'd1;
    localparam logic [1:0] StSat = 2'd2;

    localparam logic [0:0] RegColumns = 1'b0;
    localparam logic [0:0] RegDiscount = 1'b1;

    typedef struct packed {
        logic [0:0]  opcode;
        logic [5:0]  curve_index;
        logic [31:0] curve_rate;
        logic [47:0] coupon_amount;
        logic [6:0]  maturity_years;
        logic [31:0] spread_rate;
        logic [47:0] nominal_amount;
    } in_item_t;

    typedef struct packed {
        logic [47:0] flow_value;
        logic [6:0]  year_number;
        logic        last_flow;
        logic [1:0]  status;
    } out_item_t;
endpackage

### sv/bcfs_stream_if.sv
`timescale 1ns / 1ps
interface bcfs_in_if;
    logic valid;
    logic ready;
    bcfs_pkg::in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bcfs_out_if;
    logic valid;
    logic ready;
    bcfs_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### sv/bond_cash_flow_schedule.sv
`timescale 1ns / 1ps
// A load transaction writes one yield curve entry. A bond transaction emits column_count
// flows, clamped to 2 to 64, one per year. Each discounted flow is computed by one shared
// 32 by 32 multiplier, which forms (1 + yield + spread)^year by twelve squarings plus one
// multiply for each set bit of the year. A base below two is first normalised by
// single-bit shifts, up to 31 for the smallest base. A restoring divider then yields
// one quotient bit per cycle, 82 bits in all. A stalled receiver holds the schedule until
// it takes the flow. The input is not ready while a bond is in progress.
module bond_cash_flow_schedule (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [0:0] cfg_index,
    input  logic [6:0] cfg_data,
    bcfs_in_if.sink in_ch,
    bcfs_out_if.source out_ch
);
    import bcfs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_FLOW, S_NORM, S_SHIFT, S_MUL0, S_MUL1, S_DIVQ, S_DIVF, S_OUT
    } state_t;

    state_t state_reg;
    logic [31:0] curve_mem [MaxYears];
    logic [31:0] yrate_reg;
    logic [6:0] ncol_reg;
    logic disc_reg;
    logic [6:0] n_reg, mat_reg, year_reg;
    logic [47:0] cpn_reg, nom_reg;
    logic [31:0] spread_reg;
    logic [48:0] f_reg;
    logic [31:0] b_reg;
    logic [31:0] bm_reg, rm_reg;
    logic signed [12:0] be_reg, re_reg;
    logic [3:0] bit_reg;
    logic mulb_reg;
    logic [63:0] prod_reg;
    logic [113:0] rem_reg;
    logic [81:0] q_reg;
    logic [6:0] qcnt_reg;
    logic [47:0] res_value_reg;
    logic [1:0] res_status_reg;
    out_item_t out_reg;
    logic ovalid_reg;

    logic [6:0] ncl;
    logic signed [34:0] bsum;
    logic [32:0] pm;
    logic signed [12:0] pe;
    logic [11:0] year12;
    logic signed [13:0] sh;
    logic [81:0] xr;
    logic [81:0] xs;
    logic [47:0] vres;
    logic [1:0] vst;
    logic [31:0] mop;
    logic [114:0] rtry;
    logic emit;

    assign ncl = (ncol_reg < 7'd2) ? 7'd2
        : (ncol_reg > 7'(MaxYears) ? 7'(MaxYears) : ncol_reg);
    assign bsum = 35'sd1073741824 + 35'(signed'(yrate_reg)) + 35'(signed'(spread_reg));
    assign year12 = 12'(year_reg);
    assign mop = mulb_reg ? bm_reg : rm_reg;
    assign emit = (state_reg == S_OUT) && (!ovalid_reg || out_ch.ready);

    always_comb
    begin
        if (prod_reg[63])
        begin
            pm = {1'b0, prod_reg[63:32]} + 33'(prod_reg[31]);
            pe = 13'(signed'(mulb_reg ? be_reg : re_reg)) + re_reg + 13'sd32;
        end
        else
        begin
            pm = {1'b0, prod_reg[62:31]} + 33'(prod_reg[30]);
            pe = 13'(signed'(mulb_reg ? be_reg : re_reg)) + re_reg + 13'sd31;
        end
        rtry = {rem_reg, q_reg[81]} - {83'd0, rm_reg};
    end

    always_comb
    begin
        sh = -14'(re_reg) - 14'sd32;
        xr = q_reg + 82'(rem_reg >= 114'({1'b0, rm_reg[31:1]}) + 114'(rm_reg[0]) ? 1 : 0);
        xs = '0;
        vres = '0;
        vst = StOk;
        if (xr != '0)
        begin
            if (sh >= 0)
            begin
                if (sh >= 48 || xr > (82'(AmtMax) >> sh))
                begin
                    vres = AmtMax;
                    vst = StSat;
                end
                else
                    vres = 48'(xr << sh);
            end
            else if (-sh < 60)
            begin
                xs = (xr + (82'd1 << (-sh - 14'sd1))) >> (-sh);
                if (xs > 82'(AmtMax))
                begin
                    vres = AmtMax;
                    vst = StSat;
                end
                else
                    vres = xs[47:0];
            end
        end
    end

    assign in_ch.ready = (state_reg == S_IDLE);
    assign out_ch.valid = ovalid_reg;
    assign out_ch.data = out_reg;

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready && in_ch.data.opcode == OpLoad)
            curve_mem[in_ch.data.curve_index] <= in_ch.data.curve_rate;
        yrate_reg <= curve_mem[IdxW'(year_reg - 7'd1)];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ncol_reg <= 7'd64;
            disc_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    RegColumns: ncol_reg <= cfg_data;
                    RegDiscount: disc_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (emit)
                ovalid_reg <= 1'b1;
            else if (out_ch.ready)
                ovalid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid && in_ch.data.opcode == OpBond)
                    begin
                        n_reg <= ncl;
                        cpn_reg <= in_ch.data.coupon_amount;
                        nom_reg <= in_ch.data.nominal_amount;
                        mat_reg <= in_ch.data.maturity_years;
                        spread_reg <= in_ch.data.spread_rate;
                        year_reg <= 7'd1;
                        state_reg <= S_FLOW;
                    end
                end
                S_FLOW:
                begin
                    f_reg <= (year_reg <= mat_reg)
                        ? {1'b0, cpn_reg} + ((year_reg == mat_reg) ? {1'b0, nom_reg} : 49'd0)
                        : 49'd0;
                    state_reg <= S_NORM;
                end
                S_NORM:
                begin
                    if (!disc_reg)
                    begin
                        res_value_reg <= f_reg[48] ? AmtMax : f_reg[47:0];
                        res_status_reg <= f_reg[48] ? StSat : StOk;
                        state_reg <= S_OUT;
                    end
                    else if (bsum <= 0)
                    begin
                        res_value_reg <= '0;
                        res_status_reg <= StBase;
                        state_reg <= S_OUT;
                    end
                    else if (bsum[32])
                    begin
                        bm_reg <= 32'((bsum[32:0] + 33'd1) >> 1);
                        be_reg <= -13'sd29;
                        rm_reg <= 32'h8000_0000;
                        re_reg <= -13'sd31;
                        bit_reg <= 4'd11;
                        mulb_reg <= 1'b0;
                        state_reg <= S_MUL0;
                    end
                    else if (!bsum[31])
                    begin
                        b_reg <= {bsum[30:0], 1'b0};
                        be_reg <= -13'sd31;
                        state_reg <= S_SHIFT;
                    end
                    else
                    begin
                        bm_reg <= bsum[31:0];
                        be_reg <= -13'sd30;
                        rm_reg <= 32'h8000_0000;
                        re_reg <= -13'sd31;
                        bit_reg <= 4'd11;
                        mulb_reg <= 1'b0;
                        state_reg <= S_MUL0;
                    end
                end
                S_SHIFT:
                begin
                    if (b_reg[31])
                    begin
                        bm_reg <= b_reg;
                        rm_reg <= 32'h8000_0000;
                        re_reg <= -13'sd31;
                        bit_reg <= 4'd11;
                        mulb_reg <= 1'b0;
                        state_reg <= S_MUL0;
                    end
                    else
                    begin
                        b_reg <= {b_reg[30:0], 1'b0};
                        be_reg <= be_reg - 13'sd1;
                    end
                end
                S_MUL0:
                begin
                    prod_reg <= 64'(rm_reg) * 64'(mop);
                    state_reg <= S_MUL1;
                end
                S_MUL1:
                begin
                    if (pm[32])
                    begin
                        rm_reg <= 32'h8000_0000;
                        re_reg <= pe + 13'sd1;
                    end
                    else
                    begin
                        rm_reg <= pm[31:0];
                        re_reg <= pe;
                    end
                    if (!mulb_reg && year12[bit_reg])
                    begin
                        mulb_reg <= 1'b1;
                        state_reg <= S_MUL0;
                    end
                    else if (bit_reg != 4'd0)
                    begin
                        mulb_reg <= 1'b0;
                        bit_reg <= bit_reg - 4'd1;
                        state_reg <= S_MUL0;
                    end
                    else
                    begin
                        rem_reg <= '0;
                        q_reg <= 82'(f_reg) << 32;
                        qcnt_reg <= 7'd82;
                        state_reg <= S_DIVQ;
                    end
                end
                S_DIVQ:
                begin
                    if (!rtry[114])
                    begin
                        rem_reg <= rtry[113:0];
                        q_reg <= {q_reg[80:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= {rem_reg[112:0], q_reg[81]};
                        q_reg <= {q_reg[80:0], 1'b0};
                    end
                    qcnt_reg <= qcnt_reg - 7'd1;
                    if (qcnt_reg == 7'd1)
                        state_reg <= S_DIVF;
                end
                S_DIVF:
                begin
                    res_value_reg <= vres;
                    res_status_reg <= vst;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (emit)
                    begin
                        out_reg.flow_value <= res_value_reg;
                        out_reg.status <= res_status_reg;
                        out_reg.year_number <= year_reg;
                        out_reg.last_flow <= (year_reg == n_reg);
                        year_reg <= year_reg + 7'd1;
                        state_reg <= (year_reg == n_reg) ? S_IDLE : S_FLOW;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

### sv/bcfs_checker.sv
`timescale 1ns / 1ps
module bcfs_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic out_last,
    input logic [6:0] out_year,
    input logic [1:0] out_status
);
    import bcfs_pkg::*;

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_year))
        else $error("result changed while stalled");
    a_year: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_year != 7'd0)
        else $error("year zero emitted");
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_status != 2'd3)
        else $error("bad status");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_last |-> !in_ready)
        else $error("input ready mid schedule");
endmodule

bind bond_cash_flow_schedule bcfs_checker u_bcfs_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_last(out_ch.data.last_flow), .out_year(out_ch.data.year_number),
    .out_status(out_ch.data.status)
);
